[rtl/core/case_folded_fnv1_symbol_interner_macros.svh]
// ---------------------------------------------------------------------------
// Symbol interner assertion macros
// Assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef CASE_FOLDED_FNV1_SYMBOL_INTERNER_MACROS_SVH
`define CASE_FOLDED_FNV1_SYMBOL_INTERNER_MACROS_SVH
`ifndef SYNTHESIS
`define SI_ASSERT_IMP(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define SI_ASSERT_NXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define SI_ASSERT_IMP(lbl, clk, rst, a, c, msg)
`define SI_ASSERT_NXT(lbl, clk, rst, a, c, msg)
`endif
`endif

[rtl/core/cfsi_pkg.sv]
// ---------------------------------------------------------------------------
// Symbol interner package
// Sizes, constants, states and helpers shared by the interner modules.
// ---------------------------------------------------------------------------
package cfsi_pkg;
  localparam int TableDepth = 256;
  localparam int ArenaBytes = 4096;
  localparam int TW = $clog2(TableDepth);
  localparam int AW = $clog2(ArenaBytes);
  localparam logic [63:0] FnvBasis = 64'd14695981039346656037;
  localparam logic [63:0] FnvPrime = 64'd1099511628211;
  localparam logic [1:0] OUT_OK = 2'd0;
  localparam logic [1:0] OUT_TABLE_FULL = 2'd1;
  localparam logic [1:0] OUT_ARENA_FULL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SEARCH, ST_CMP, ST_DECIDE, ST_TERM, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [63:0] hash;
  } mul_req_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
    return b;
  endfunction
endpackage

[rtl/core/cfsi_mul.sv]
// ---------------------------------------------------------------------------
// Symbol interner prime multiplier
// Iterative 64x64 low-half product, one 16-bit digit of the prime per cycle.
// ---------------------------------------------------------------------------
module cfsi_mul import cfsi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mul_req_t    req,
  output logic        done,
  output logic [63:0] product
);
  logic [63:0] acc;
  logic [63:0] mcand;
  logic [1:0]  step;
  logic        busy;
  logic [15:0] digit;
  logic [79:0] part;

  always_comb begin
    case (step)
      2'd0: digit = FnvPrime[15:0];
      2'd1: digit = FnvPrime[31:16];
      2'd2: digit = FnvPrime[47:32];
      default: digit = FnvPrime[63:48];
    endcase
    part = mcand * digit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        acc <= '0;
        mcand <= req.hash;
      end else if (busy) begin
        acc <= acc + part[63:0];
        mcand <= {mcand[47:0], 16'd0};
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;
endmodule

[rtl/core/case_folded_fnv1_symbol_interner.sv]
// ---------------------------------------------------------------------------
// Case-folded FNV-1 symbol interner
// Hashes symbol names byte by byte and interns them in a byte arena.
// ---------------------------------------------------------------------------
// Input s_axis: one name byte per item, tlast on the final byte.
// Output m_axis: one result item per final byte, none for other bytes.
// Each byte runs through the multiplier, one 16-bit slice of the prime
// multiply per cycle. A final byte then scans the entry table one entry at a
// time, a SEARCH state over the registered table read and a CMP state; a hit
// ends the scan early. The DECIDE and TERM states follow, TERM committing
// the terminator, before the result is valid in OUT.
// The block is not ready while an item is at work or a result waits.
// A stalled receiver holds the result in the output register; the block
// takes no new item until it is taken.
// Reset empties the table and arena (count and top registers only) and
// restarts the hash; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "case_folded_fnv1_symbol_interner_macros.svh"
module case_folded_fnv1_symbol_interner import cfsi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // name_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // name_hash, newly_added, name_offset, outcome, pad
  output logic        m_axis_tlast
);
  state_t state, state_next;
  logic [63:0] hash;
  logic [AW:0] plen;
  logic [AW:0] top;
  logic [TW:0] count;
  logic [TW:0] idx;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [63:0] ent_hash [TableDepth];
  logic [AW-1:0] ent_off [TableDepth];
  logic [7:0]  arena [ArenaBytes];
  logic [63:0] rd_hash;
  logic [AW-1:0] rd_off;
  logic        found;
  logic [AW-1:0] found_off;
  logic [63:0] o_hash;
  logic        o_new;
  logic [AW-1:0] o_off;
  logic [1:0]  o_outc;
  mul_req_t    mreq;
  logic        mdone;
  logic [63:0] mprod;
  logic [AW+1:0] pos;
  logic        accept;

  cfsi_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mdone), .product(mprod));

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign mreq.start = accept;
  assign mreq.hash = hash;
  assign pos = {1'b0, top} + {1'b0, plen};

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_MUL;
      ST_MUL: if (mdone) state_next = last_q ? ST_SEARCH : ST_IDLE;
      ST_SEARCH: state_next = (idx < count) ? ST_CMP : ST_DECIDE;
      ST_CMP: state_next = (rd_hash == hash) ? ST_DECIDE : ST_SEARCH;
      ST_DECIDE: state_next = ST_TERM;
      ST_TERM: state_next = ST_OUT;
      ST_OUT: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEARCH) begin
      rd_hash <= ent_hash[idx[TW-1:0]];
      rd_off <= ent_off[idx[TW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL && mdone && plen <= (AW+1)'(ArenaBytes)
        && pos < (AW+2)'(ArenaBytes))
      arena[pos[AW-1:0]] <= byte_q;
    else if (state == ST_TERM && o_new)
      arena[pos[AW-1:0]] <= 8'd0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_TERM && o_new) begin
      ent_hash[count[TW-1:0]] <= hash;
      ent_off[count[TW-1:0]] <= top[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= FnvBasis;
      plen <= '0;
      top <= '0;
      count <= '0;
      idx <= '0;
      found <= 1'b0;
      o_new <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (accept) begin
          byte_q <= s_axis_tdata;
          last_q <= s_axis_tlast;
        end
        ST_MUL: if (mdone) begin
          hash <= mprod ^ {56'd0, fold_case(byte_q)};
          if (plen <= (AW+1)'(ArenaBytes)) plen <= plen + 1'b1;
          idx <= '0;
          found <= 1'b0;
        end
        ST_CMP: begin
          idx <= idx + 1'b1;
          if (rd_hash == hash) begin
            found <= 1'b1;
            found_off <= rd_off;
          end
        end
        ST_DECIDE: begin
          o_hash <= hash;
          o_new <= 1'b0;
          o_off <= '0;
          o_outc <= OUT_OK;
          if (found) o_off <= found_off;
          else if (count >= (TW+1)'(TableDepth)) o_outc <= OUT_TABLE_FULL;
          else if (plen > (AW+1)'(ArenaBytes) || pos + 1'b1 > (AW+2)'(ArenaBytes))
            o_outc <= OUT_ARENA_FULL;
          else begin
            o_new <= 1'b1;
            o_off <= top[AW-1:0];
          end
        end
        ST_TERM: begin
          if (o_new) begin
            count <= count + 1'b1;
            top <= pos[AW:0] + 1'b1;
          end
          hash <= FnvBasis;
          plen <= '0;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = {1'b0, o_outc, o_off, o_new, o_hash};
  assign m_axis_tlast = 1'b1;

  `SI_ASSERT_IMP(a_ready_idle, clk, rst, s_axis_tready, !m_axis_tvalid, "ready while result pending")
  `SI_ASSERT_NXT(a_count_hold, clk, rst, state != ST_TERM, $stable(count) || $past(rst), "count moved outside commit")
  `SI_ASSERT_IMP(a_new_ok, clk, rst, m_axis_tvalid && o_new, o_outc == OUT_OK, "insert with error outcome")
endmodule

[tb/case_folded_fnv1_symbol_interner_tb.sv]
// ---------------------------------------------------------------------------
// Symbol interner testbench
// Sends symbol names byte by byte over the input stream, with bursts and
// gaps, while the output side stalls on its own pattern. A local model
// tracks the folded hash, the entry table and the arena top. Every result
// item is checked field by field against the oldest prediction. The run
// covers case variants, hits, inserts, and enough fresh names to fill the
// table.
// ---------------------------------------------------------------------------
module case_folded_fnv1_symbol_interner_tb;
  import cfsi_pkg::*;

  typedef struct {
    logic [7:0] name_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct {
    logic [63:0] name_hash;
    logic        newly_added;
    logic [11:0] name_offset;
    logic [1:0]  outcome;
  } intern_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;  // name_byte
  logic        s_axis_tlast = 1'b0;  // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;         // name_hash, newly_added, name_offset, outcome, pad
  logic        m_axis_tlast;

  case_folded_fnv1_symbol_interner u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk = ~clk;

  byte_item_t     name_bytes_q[$];
  intern_result_t lookups_q[$];

  logic [63:0] hash_acc;
  int unsigned name_len;
  int unsigned arena_fill;
  int unsigned entries_used;
  logic [63:0] stored_hash[TableDepth];
  logic [11:0] stored_offset[TableDepth];

  int errors = 0;
  int n_hit = 0, n_insert = 0, n_table_full = 0, n_arena_full = 0;
  int n_bytes_sent = 0;
  int n_queued = 0;
  int unsigned cycles = 0;

  function automatic logic [7:0] lower_ascii(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
  endfunction

  task automatic intern_byte(input byte_item_t it);
    intern_result_t r;
    bit hit;
    logic [11:0] hit_off;
    hit = 1'b0;
    hit_off = '0;
    hash_acc = (hash_acc * FnvPrime) ^ {56'd0, lower_ascii(it.name_byte)};
    if (name_len <= ArenaBytes) name_len++;
    if (it.last_byte) begin
      for (int i = 0; i < entries_used; i++)
        if (!hit && stored_hash[i] == hash_acc) begin
          hit = 1'b1;
          hit_off = stored_offset[i];
        end
      r.name_hash = hash_acc;
      r.newly_added = 1'b0;
      r.name_offset = '0;
      if (hit) begin
        r.name_offset = hit_off;
        r.outcome = OUT_OK;
        n_hit++;
      end else if (entries_used >= TableDepth) begin
        r.outcome = OUT_TABLE_FULL;
        n_table_full++;
      end else if (name_len > ArenaBytes || arena_fill + name_len + 1 > ArenaBytes) begin
        r.outcome = OUT_ARENA_FULL;
        n_arena_full++;
      end else begin
        stored_hash[entries_used] = hash_acc;
        stored_offset[entries_used] = arena_fill[11:0];
        entries_used++;
        r.newly_added = 1'b1;
        r.name_offset = arena_fill[11:0];
        r.outcome = OUT_OK;
        arena_fill = arena_fill + name_len + 1;
        n_insert++;
      end
      lookups_q.push_back(r);
      hash_acc = FnvBasis;
      name_len = 0;
    end
  endtask

  // Driver: bursts of random length with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    byte_item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.name_byte = s_axis_tdata;
        it.last_byte = s_axis_tlast;
        intern_byte(it);
        n_bytes_sent++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (name_bytes_q.size() > 0) begin
          it = name_bytes_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= it.name_byte;
          s_axis_tlast <= it.last_byte;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall pattern plus one long hold-off.
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    intern_result_t e;
    bit rdy;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (lookups_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
          errors++;
        end else begin
          e = lookups_q.pop_front();
          if (m_axis_tdata[63:0] !== e.name_hash) begin
            $display("%0t: name_hash expected %h actual %h", $time, e.name_hash,
                     m_axis_tdata[63:0]);
            errors++;
          end
          if (m_axis_tdata[64] !== e.newly_added) begin
            $display("%0t: newly_added expected %b actual %b", $time, e.newly_added,
                     m_axis_tdata[64]);
            errors++;
          end
          if (m_axis_tdata[76:65] !== e.name_offset) begin
            $display("%0t: name_offset expected %0d actual %0d", $time, e.name_offset,
                     m_axis_tdata[76:65]);
            errors++;
          end
          if (m_axis_tdata[78:77] !== e.outcome) begin
            $display("%0t: outcome expected %0d actual %0d", $time, e.outcome,
                     m_axis_tdata[78:77]);
            errors++;
          end
        end
      end
      if (!hold_done && n_bytes_sent > 600) begin
        hold_done = 1'b1;
        hold_left = 3000;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 400);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (stall_mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 3) != 0);
          default: rdy = ($urandom_range(0, 5) == 0);
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 6000000) begin
      $display("case_folded_fnv1_symbol_interner_tb: errors");
      $finish;
    end
  end

  logic [7:0] pool_name[64][16];
  int         pool_len[64];
  int         pool_size = 0;

  task automatic queue_name(input logic [7:0] nm[16], input int len);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      it.name_byte = nm[i];
      it.last_byte = (i == len - 1);
      name_bytes_q.push_back(it);
    end
    n_queued += len;
  endtask

  task automatic queue_fresh(input int len, input bit letters);
    logic [7:0] nm[16];
    for (int i = 0; i < len; i++)
      nm[i] = letters ? (8'h41 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00))
                      : 8'($urandom);
    queue_name(nm, len);
    if (pool_size < 64) begin
      pool_name[pool_size] = nm;
      pool_len[pool_size] = len;
      pool_size++;
    end
  endtask

  initial begin
    logic [7:0] nm[16];
    int k;
    hash_acc = FnvBasis;
    name_len = 0;
    arena_fill = 0;
    entries_used = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: case folding, boundary bytes, hit on case variant.
    nm = '{default: 8'h00};
    nm[0] = 8'h41; nm[1] = 8'h5A; nm[2] = 8'h40; nm[3] = 8'h5B;
    queue_name(nm, 4);
    nm[0] = 8'h61; nm[1] = 8'h7A; nm[2] = 8'h40; nm[3] = 8'h5B;
    queue_name(nm, 4);
    nm[0] = 8'h00; queue_name(nm, 1);
    nm[0] = 8'hFF; queue_name(nm, 1);
    nm[0] = 8'h60; queue_name(nm, 1);
    nm[0] = 8'h7B; queue_name(nm, 1);
    nm[0] = 8'hFF; queue_name(nm, 1);
    nm[0] = 8'h5A; nm[1] = 8'h80; nm[2] = 8'h7F; queue_name(nm, 3);
    nm[0] = 8'h7A; queue_name(nm, 3);

    // Random: fresh names, case-flipped repeats, noise.
    while (n_queued < 300) begin
      k = $urandom_range(0, 9);
      if (k < 5 || pool_size == 0) begin
        queue_fresh($urandom_range(1, 12), k != 0);
      end else if (k < 9) begin
        k = $urandom_range(0, pool_size - 1);
        nm = pool_name[k];
        for (int i = 0; i < pool_len[k]; i++)
          if (lower_ascii(nm[i]) >= 8'h61 && lower_ascii(nm[i]) <= 8'h7A && $urandom_range(0, 1))
            nm[i] = nm[i] ^ 8'h20;
        queue_name(nm, pool_len[k]);
      end else begin
        for (int i = 0; i < 16; i++) nm[i] = 8'($urandom);
        queue_name(nm, $urandom_range(1, 3));
      end
    end

    // Fill the table, then keep going past it.
    for (int j = 0; j < 300; j++) queue_fresh($urandom_range(2, 4), 1'b0);
    for (int j = 0; j < 20 && pool_size > 0; j++) begin
      k = $urandom_range(0, pool_size - 1);
      queue_name(pool_name[k], pool_len[k]);
    end

    wait (n_bytes_sent == n_queued && lookups_q.size() == 0);
    repeat (1200) @(posedge clk);
    $display("names interned %0d, hits %0d, table full %0d, arena full %0d", n_insert, n_hit,
             n_table_full, n_arena_full);
    $display("bytes sent %0d over %0d cycles", n_bytes_sent, cycles);
    if (errors == 0 && lookups_q.size() == 0) begin
      $display("case_folded_fnv1_symbol_interner_tb: clean");
    end else begin
      $display("case_folded_fnv1_symbol_interner_tb: errors");
    end
    $finish;
  end
endmodule
